[rtl/sorted_set_engine_macros.svh]
// Assertion macros used by the sorted set engine datapath.
`ifndef SORTED_SET_ENGINE_MACROS_SVH
`define SORTED_SET_ENGINE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset.
`define SSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set engine check failed");

// Next-cycle implication, disabled while in reset.
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set engine check failed");

`else

`define SSE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/sse_pkg.sv]
// Types and constants shared by the sorted set engine modules.
package sse_pkg;

    localparam int OP_W       = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_W      = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam int TREE_FANIN = 8;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MEMBER = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_COMPARE = 2'd1,
        S_REDUCE  = 2'd2,
        S_UPDATE  = 2'd3
    } state_t;

    typedef struct packed {
        logic load;     // capture the input item
        logic compare;  // register per-entry compare flags
        logic update;   // apply the operation and load the result register
    } cmd_t;

    typedef struct packed {
        logic out_valid;
    } sts_t;

endpackage

[rtl/sse_ctrl.sv]
// Controller state machine for the sorted set engine.
module sse_ctrl #(
    parameter int LEVELS = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    input  sse_pkg::sts_t sts,
    output sse_pkg::cmd_t cmd
);

    localparam int RC_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    sse_pkg::state_t state_reg, state_next;
    logic [RC_W-1:0] red_cnt_reg, red_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sse_pkg::S_IDLE;
            red_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            red_cnt_reg <= red_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        red_cnt_next = red_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            sse_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sse_pkg::S_COMPARE;
                end
            end
            sse_pkg::S_COMPARE: begin
                cmd.compare  = 1'b1;
                red_cnt_next = '0;
                state_next   = sse_pkg::S_REDUCE;
            end
            sse_pkg::S_REDUCE: begin
                // wait for the hit flags to climb the OR tree
                if (red_cnt_reg == RC_W'(LEVELS - 1)) begin
                    state_next = sse_pkg::S_UPDATE;
                end else begin
                    red_cnt_next = red_cnt_reg + 1'b1;
                end
            end
            sse_pkg::S_UPDATE: begin
                // result register must be free before the set changes
                if (!sts.out_valid || m_tready) begin
                    cmd.update = 1'b1;
                    state_next = sse_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sse_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/sse_dp.sv]
// Datapath: sorted register row with per-entry compare and shift, hit tree, result register.
module sse_dp #(
    parameter int CAPACITY = 64,
    parameter int LEVELS   = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sse_pkg::cmd_t                    cmd,
    output sse_pkg::sts_t                    sts,
    input  logic [sse_pkg::OP_W-1:0]         in_op,
    input  logic [sse_pkg::VALUE_W-1:0]      in_value,
    input  logic                             cfg_we,
    input  logic [sse_pkg::CFG_W-1:0]        cfg_size,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [sse_pkg::STATUS_W-1:0]     out_status,
    output logic [sse_pkg::COUNT_W-1:0]      out_count,
    output logic                             out_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LIM_W = (CNT_W > sse_pkg::CFG_W) ? CNT_W : sse_pkg::CFG_W;
    localparam int FAN   = sse_pkg::TREE_FANIN;

    logic signed [sse_pkg::VALUE_W-1:0] elem_reg [CAPACITY];
    logic signed [sse_pkg::VALUE_W-1:0] elem_next [CAPACITY];
    logic signed [sse_pkg::VALUE_W-1:0] value_reg;
    sse_pkg::op_t                       op_reg;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [sse_pkg::CFG_W-1:0]          size_reg;

    logic [CAPACITY-1:0] lt_reg, lt_next;
    logic [CAPACITY-1:0] hit_lvl_reg  [LEVELS+1];
    logic [CAPACITY-1:0] hit_lvl_next [LEVELS+1];

    logic                      out_valid_reg, out_valid_next;
    sse_pkg::status_t          status_reg, status_next;
    logic [sse_pkg::COUNT_W-1:0] out_count_reg;
    logic                      empty_reg;

    logic [LIM_W-1:0] limit;
    logic             full, present, insert_ok, remove_ok;

    // per-entry compare against the held value, entries at or above the count masked
    always_comb begin
        lt_next         = lt_reg;
        hit_lvl_next[0] = hit_lvl_reg[0];
        if (cmd.compare) begin
            for (int i = 0; i < CAPACITY; i++) begin
                lt_next[i]         = (CNT_W'(i) < count_reg) && (elem_reg[i] < value_reg);
                hit_lvl_next[0][i] = (CNT_W'(i) < count_reg) && (elem_reg[i] == value_reg);
            end
        end

        // registered OR tree, eight inputs per node
        for (int l = 1; l <= LEVELS; l++) begin
            hit_lvl_next[l] = '0;
            for (int j = 0; j < CAPACITY; j++) begin
                for (int k = 0; k < FAN; k++) begin
                    if (FAN * j + k < CAPACITY) begin
                        hit_lvl_next[l][j] = hit_lvl_next[l][j] | hit_lvl_reg[l-1][FAN * j + k];
                    end
                end
            end
        end
    end

    always_comb begin
        limit = (LIM_W'(size_reg) > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : LIM_W'(size_reg);
        full      = LIM_W'(count_reg) >= limit;
        present   = hit_lvl_reg[LEVELS][0];
        insert_ok = (op_reg == sse_pkg::OP_INSERT) && !full && !present;
        remove_ok = (op_reg == sse_pkg::OP_REMOVE) && present;
    end

    // insert opens a slot at the first entry not below the value; remove closes it
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            elem_next[i] = elem_reg[i];
            if (insert_ok && !lt_reg[i]) begin
                if (i == 0) begin
                    elem_next[i] = value_reg;
                end else if (lt_reg[i-1]) begin
                    elem_next[i] = value_reg;
                end else begin
                    elem_next[i] = elem_reg[i-1];
                end
            end else if (remove_ok && !lt_reg[i] && (i < CAPACITY - 1)) begin
                elem_next[i] = elem_reg[i+1];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (insert_ok) begin
            count_next = count_reg + 1'b1;
        end else if (remove_ok) begin
            count_next = count_reg - 1'b1;
        end

        case (op_reg)
            sse_pkg::OP_INSERT: begin
                if (full) begin
                    status_next = sse_pkg::ST_FULL;
                end else if (present) begin
                    status_next = sse_pkg::ST_MISS;
                end else begin
                    status_next = sse_pkg::ST_DONE;
                end
            end
            sse_pkg::OP_REMOVE, sse_pkg::OP_MEMBER: begin
                status_next = present ? sse_pkg::ST_DONE : sse_pkg::ST_MISS;
            end
            default: begin
                status_next = sse_pkg::ST_DONE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.update) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            size_reg      <= sse_pkg::SIZE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.update) begin
                count_reg <= count_next;
            end
            if (cfg_we) begin
                size_reg <= cfg_size;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= sse_pkg::op_t'(in_op);
            value_reg <= $signed(in_value);
        end
        lt_reg <= lt_next;
        for (int l = 0; l <= LEVELS; l++) begin
            hit_lvl_reg[l] <= hit_lvl_next[l];
        end
        if (cmd.update) begin
            for (int i = 0; i < CAPACITY; i++) begin
                elem_reg[i] <= elem_next[i];
            end
            status_reg    <= status_next;
            out_count_reg <= sse_pkg::COUNT_W'(count_next);
            empty_reg     <= (count_next == '0);
        end
    end

    assign sts.out_valid = out_valid_reg;
    assign m_tvalid      = out_valid_reg;
    assign out_status    = status_reg;
    assign out_count     = out_count_reg;
    assign out_is_empty  = empty_reg;

`include "sorted_set_engine_macros.svh"

    `SSE_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SSE_ASSERT_NOW(a_update_slot_free, aclk, aresetn, cmd.update, !out_valid_reg || m_tready)
    `SSE_ASSERT_NEXT(a_update_shows, aclk, aresetn, cmd.update, out_valid_reg)
    `SSE_ASSERT_NEXT(a_insert_grows, aclk, aresetn, cmd.update && insert_ok, count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule

[rtl/sorted_set_engine.sv]
// Sorted set engine: ordered store of distinct signed 32-bit values with insert/remove/member.
// Sequence per item: the input transfer is captured, the compare flags are registered, the hits
//   climb LEVELS = ceil(log8(CAPACITY)) stages of the registered hit OR tree (2 at CAPACITY 64),
//   then the update loads the result register once it is free; new input is taken only in idle.
// Reset (aresetn low, synchronous): count 0, size_in_use 64, no result pending;
//   stored entries are not cleared, only entries below the count are ever used.
module sorted_set_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sse_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] value
    input  logic [sse_pkg::OP_W-1:0]         s_tuser,   // [1:0] op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sse_pkg::OUT_DATA_W-1:0]   m_tdata,   // [1:0] status, [8:2] count, [9] is_empty
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sse_pkg::CFG_W-1:0]        cfg_data   // size_in_use
);

    localparam int LEVELS = (CAPACITY > 1) ? ($clog2(CAPACITY) + 2) / 3 : 1;

    sse_pkg::cmd_t cmd;
    sse_pkg::sts_t sts;

    logic [sse_pkg::STATUS_W-1:0] out_status;
    logic [sse_pkg::COUNT_W-1:0]  out_count;
    logic                         out_is_empty;

    assign cfg_ready = 1'b1;

    sse_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sse_dp #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_op        (s_tuser),
        .in_value     (s_tdata),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_size     (cfg_data),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_status   (out_status),
        .out_count    (out_count),
        .out_is_empty (out_is_empty)
    );

    assign m_tdata = {6'd0, out_is_empty, out_count, out_status};

endmodule

[tb/sorted_set_engine_tb.sv]
// Self-checking testbench for sorted_set_engine: directed table, then random traffic of all four ops.
module sorted_set_engine_tb;

    localparam int SET_CAPACITY = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam int NUM_PHASES   = 8;
    localparam int POOL_SIZE    = 96;

    typedef struct packed {
        sse_pkg::status_t status;
        logic [6:0]       count;
        logic             is_empty;
    } set_result_t;

    // One directed step: either a size write (value holds the new size) or an operation.
    typedef struct packed {
        logic             is_cfg;
        sse_pkg::op_t     op;
        logic [31:0]      value;
        logic             typed;
        sse_pkg::status_t status;
        logic [6:0]       count;
        logic             is_empty;
    } plan_row_t;

    localparam int PLAN_ROWS = 30;
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{1'b0, sse_pkg::OP_MEMBER, 32'h0000_0000, 1'b1, sse_pkg::ST_MISS, 7'd0, 1'b1},
        '{1'b0, sse_pkg::OP_REMOVE, 32'h0000_0005, 1'b1, sse_pkg::ST_MISS, 7'd0, 1'b1},
        '{1'b0, sse_pkg::OP_RSVD,   32'h0000_0000, 1'b1, sse_pkg::ST_DONE, 7'd0, 1'b1},
        '{1'b0, sse_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, sse_pkg::ST_DONE, 7'd1, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h8000_0000, 1'b1, sse_pkg::ST_DONE, 7'd2, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0000, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0000, 1'b1, sse_pkg::ST_MISS, 7'd3, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0001, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_MEMBER, 32'h8000_0000, 1'b1, sse_pkg::ST_DONE, 7'd5, 1'b0},
        '{1'b0, sse_pkg::OP_MEMBER, 32'h0000_0002, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_RSVD,   32'hFFFF_FFFF, 1'b1, sse_pkg::ST_DONE, 7'd5, 1'b0},
        '{1'b0, sse_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, sse_pkg::ST_MISS, 7'd4, 1'b0},
        '{1'b0, sse_pkg::OP_REMOVE, 32'h8000_0000, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b1, sse_pkg::OP_INSERT, 32'd3,         1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0005, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0006, 1'b1, sse_pkg::ST_FULL, 7'd3, 1'b0},
        // full wins over duplicate
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0005, 1'b1, sse_pkg::ST_FULL, 7'd3, 1'b0},
        // limit dropped below the count: elements stay, inserts refused
        '{1'b1, sse_pkg::OP_INSERT, 32'd1,         1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0007, 1'b1, sse_pkg::ST_FULL, 7'd3, 1'b0},
        '{1'b0, sse_pkg::OP_REMOVE, 32'h0000_0005, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_MEMBER, 32'hFFFF_FFFF, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b1, sse_pkg::OP_INSERT, 32'd0,         1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_REMOVE, 32'h0000_0001, 1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, sse_pkg::ST_DONE, 7'd0, 1'b1},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0004, 1'b1, sse_pkg::ST_FULL, 7'd0, 1'b1},
        // above capacity acts as capacity
        '{1'b1, sse_pkg::OP_INSERT, 32'd127,       1'b0, sse_pkg::ST_DONE, 7'd0, 1'b0},
        '{1'b0, sse_pkg::OP_INSERT, 32'h0000_0004, 1'b1, sse_pkg::ST_DONE, 7'd1, 1'b0}
    };

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [sse_pkg::IN_DATA_W-1:0]    s_tdata   = '0;   // [31:0] value
    logic [sse_pkg::OP_W-1:0]         s_tuser   = '0;   // [1:0] op
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [sse_pkg::OUT_DATA_W-1:0]   m_tdata;          // [1:0] status, [8:2] count, [9] is_empty
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [sse_pkg::CFG_W-1:0]        cfg_data  = '0;

    // predictor state: the set in ascending order and the size limit
    logic signed [31:0] set_contents[$];
    logic [6:0]         size_limit = sse_pkg::SIZE_RESET;

    set_result_t        expected_results[$];
    logic [31:0]        value_pool [POOL_SIZE];

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int error_count    = 0;
    int ops_sent       = 0;
    int results_seen   = 0;
    int full_seen      = 0;
    int size_writes    = 0;
    int peak_count     = 0;

    sorted_set_engine #(
        .CAPACITY(SET_CAPACITY)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic set_result_t apply_set_op(input sse_pkg::op_t op,
                                                 input logic signed [31:0] v);
        set_result_t res;
        int          pos;
        int          limit;
        bit          hit;
        pos = 0;
        while (pos < set_contents.size() && set_contents[pos] < v)
            pos++;
        hit   = (pos < set_contents.size()) && (set_contents[pos] == v);
        limit = (size_limit > SET_CAPACITY) ? SET_CAPACITY : int'(size_limit);
        res.status = sse_pkg::ST_DONE;
        case (op)
            sse_pkg::OP_INSERT: begin
                if (set_contents.size() >= limit)
                    res.status = sse_pkg::ST_FULL;
                else if (hit)
                    res.status = sse_pkg::ST_MISS;
                else
                    set_contents.insert(pos, v);
            end
            sse_pkg::OP_REMOVE: begin
                if (hit)
                    set_contents.delete(pos);
                else
                    res.status = sse_pkg::ST_MISS;
            end
            sse_pkg::OP_MEMBER: begin
                res.status = hit ? sse_pkg::ST_DONE : sse_pkg::ST_MISS;
            end
            default: begin
                res.status = sse_pkg::ST_DONE;
            end
        endcase
        res.count    = 7'(set_contents.size());
        res.is_empty = (set_contents.size() == 0);
        return res;
    endfunction

    task automatic send_op(input sse_pkg::op_t op, input logic [31:0] v, input logic typed,
                           input set_result_t typed_res);
        set_result_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        res = apply_set_op(op, v);
        expected_results.push_back(typed ? typed_res : res);
        ops_sent++;
        if (set_contents.size() > peak_count)
            peak_count = set_contents.size();
    endtask

    // size writes happen only with the engine idle
    task automatic write_size_limit(input logic [6:0] new_size);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= new_size;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        size_limit = new_size;
        size_writes++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return $urandom();
            1: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            2, 3: begin
                if (set_contents.size() != 0)
                    return set_contents[$urandom_range(set_contents.size() - 1)];
                return value_pool[$urandom_range(POOL_SIZE - 1)];
            end
            default: return value_pool[$urandom_range(POOL_SIZE - 1)];
        endcase
    endfunction

    function automatic sse_pkg::op_t pick_op(input int insert_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return sse_pkg::OP_RSVD;
        if (r < 3 + insert_pct)
            return sse_pkg::OP_INSERT;
        if (r < 3 + insert_pct + (97 - insert_pct) / 2)
            return sse_pkg::OP_REMOVE;
        return sse_pkg::OP_MEMBER;
    endfunction

    always @(posedge aclk) begin
        set_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer, m_tdata %h", m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                if (m_tdata[1:0] == sse_pkg::ST_FULL)
                    full_seen++;
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[8:2] !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_tdata[8:2]);
                    error_count++;
                end
                if (m_tdata[9] !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, m_tdata[9]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("sorted_set_engine_tb failed");
        $finish;
    end

    initial begin
        logic [6:0]  phase_sizes [NUM_PHASES];
        set_result_t row_res;
        int          insert_pct;
        phase_sizes = '{7'd64, 7'd127, 7'd8, 7'd0, 7'd65, 7'd1, 7'd40, 7'd64};
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = (i % 3 == 0) ? $urandom() : 32'($signed($urandom_range(200)) - 100);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                write_size_limit(directed_plan[i].value[6:0]);
            end else begin
                row_res.status   = directed_plan[i].status;
                row_res.count    = directed_plan[i].count;
                row_res.is_empty = directed_plan[i].is_empty;
                send_op(directed_plan[i].op, directed_plan[i].value,
                        directed_plan[i].typed, row_res);
            end
        end

        // idle mix per phase: none, sender gaps, receiver stalls, light both
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_size_limit(phase_sizes[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
            endcase
            insert_pct = (p % 2 == 0) ? 65 : 35;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_op(pick_op(insert_pct), pick_value(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operations and %0d size writes; %0d results checked",
                 ops_sent, size_writes, results_seen);
        $display("set grew to %0d elements, %0d inserts refused as full", peak_count, full_seen);
        if (error_count == 0)
            $display("sorted_set_engine_tb passed");
        else
            $display("sorted_set_engine_tb failed");
        $finish;
    end

endmodule
